// File: design/assert_macros.svh
// assertion helpers shared by sfd_front and sfd_queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// expression that must never be true outside reset
`define SFD_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// File: design/sfd_pkg.sv
package sfd_pkg;

    // configuration register indexes
    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CFG_HEADER_BYTE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 2'd1;

    // register reset values
    localparam logic [7:0] HEADER_BYTE_RST = 8'd165;
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd200;

    // header window and length quirk
    localparam int HdrBytes = 8;
    localparam int FillW    = $clog2(HdrBytes);
    localparam logic [7:0]  QUIRK_ID_LO  = 8'h20;
    localparam logic [7:0]  QUIRK_ID_HI  = 8'h00;
    localparam logic [15:0] QUIRK_LEN    = 16'd22;
    localparam logic [7:0]  QUIRK_USELEN = 8'd20;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // queue between front and back
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // compact result record: val is {index, data} for a payload beat, crc for frame end
    typedef struct packed {
        logic        kind;
        logic [15:0] msg_id;
        logic [7:0]  len;
        logic [15:0] val;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: design/sfd_in_if.sv
interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: design/sfd_out_if.sv
interface sfd_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] msg_id;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  frame_len;
    logic [15:0] frame_crc;

    modport source (output valid, output kind, output msg_id, output data_byte,
                    output byte_index, output frame_len, output frame_crc, input ready);
    modport sink   (input valid, input kind, input msg_id, input data_byte,
                    input byte_index, input frame_len, input frame_crc, output ready);
endinterface

// File: design/sfd_front.sv
`include "assert_macros.svh"

module sfd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sfd_in_if.sink                       i_rx,
    input  logic                         i_cfg_we,
    input  logic [sfd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [7:0]                   i_cfg_data,
    input  sfd_pkg::t_q_stat             i_q_stat,
    output logic                         o_push,
    output sfd_pkg::t_rec                o_rec
);
    import sfd_pkg::*;

    logic [7:0]       r_hdr_byte, r_max_len;
    logic [7:0]       r_win [HdrBytes];
    logic [7:0]       n_win [HdrBytes];
    logic [FillW-1:0] r_fill, n_fill;
    logic             r_in_frame, n_in_frame;
    logic             r_crc_phase, n_crc_phase;
    logic [7:0]       r_left, n_left;
    logic [7:0]       r_pos, n_pos;
    logic [15:0]      r_id, n_id;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_crc_lo, n_crc_lo;

    logic             accept;
    logic [7:0]       b;
    logic [7:0]       full_win [HdrBytes];
    logic [15:0]      hdr_len;
    logic             hdr_ok;

    assign i_rx.ready = !i_q_stat.full;
    assign accept     = i_rx.valid && !i_q_stat.full;
    assign b          = i_rx.rx_byte;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_byte <= HEADER_BYTE_RST;
            r_max_len  <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEADER_BYTE: r_hdr_byte <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // header check on the window completed by this beat
    always_comb begin
        for (int i = 0; i < HdrBytes - 1; i++) begin
            full_win[i] = r_win[i];
        end
        full_win[HdrBytes-1] = b;
        hdr_len = {full_win[2], full_win[1]};
        if (full_win[4] == QUIRK_ID_LO && full_win[5] == QUIRK_ID_HI
                && hdr_len == QUIRK_LEN) begin
            hdr_len = {8'd0, QUIRK_USELEN};
        end
        hdr_ok = (full_win[0] == r_hdr_byte) && (hdr_len <= {8'd0, r_max_len});
    end

    // window fill, frame tracking and result classification
    always_comb begin
        n_win       = r_win;
        n_fill      = r_fill;
        n_in_frame  = r_in_frame;
        n_crc_phase = r_crc_phase;
        n_left      = r_left;
        n_pos       = r_pos;
        n_id        = r_id;
        n_len       = r_len;
        n_crc_lo    = r_crc_lo;
        o_push      = 1'b0;
        o_rec       = '{kind: KIND_PAYLOAD, msg_id: r_id, len: r_len, val: {r_pos, b}};
        if (accept) begin
            if (r_in_frame) begin
                if (r_left != 8'd0) begin
                    o_push = 1'b1;
                    n_pos  = r_pos + 8'd1;
                    n_left = r_left - 8'd1;
                end else if (!r_crc_phase) begin
                    n_crc_lo    = b;
                    n_crc_phase = 1'b1;
                end else begin
                    o_push       = 1'b1;
                    o_rec.kind   = KIND_END;
                    o_rec.val    = {b, r_crc_lo};
                    n_in_frame   = 1'b0;
                    n_crc_phase  = 1'b0;
                    n_fill       = '0;
                end
            end else if (r_fill != FillW'(HdrBytes - 1)) begin
                n_win[r_fill] = b;
                n_fill        = r_fill + FillW'(1);
            end else if (hdr_ok) begin
                n_id        = {full_win[5], full_win[4]};
                n_len       = hdr_len[7:0];
                n_left      = hdr_len[7:0];
                n_pos       = 8'd0;
                n_crc_lo    = 8'd0;
                n_crc_phase = 1'b0;
                n_fill      = '0;
                n_in_frame  = 1'b1;
            end else begin
                // resync: drop the oldest byte
                for (int i = 0; i < HdrBytes - 1; i++) begin
                    n_win[i] = full_win[i+1];
                end
                n_win[HdrBytes-1] = 8'd0;
                n_fill = FillW'(HdrBytes - 1);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_in_frame  <= 1'b0;
            r_crc_phase <= 1'b0;
            r_left      <= 8'd0;
            r_pos       <= 8'd0;
        end else begin
            r_fill      <= n_fill;
            r_in_frame  <= n_in_frame;
            r_crc_phase <= n_crc_phase;
            r_left      <= n_left;
            r_pos       <= n_pos;
        end
    end

    // frame payload registers
    always_ff @(posedge i_clk) begin
        r_win    <= n_win;
        r_id     <= n_id;
        r_len    <= n_len;
        r_crc_lo <= n_crc_lo;
    end

    `SFD_ASSERT(a_pos_left_sum, r_in_frame |-> (r_pos + r_left) == r_len, "payload count mismatch")
    `SFD_ASSERT(a_push_in_frame, o_push |-> r_in_frame && accept, "result outside frame")
    `SFD_NEVER(a_crc_early, r_crc_phase && r_left != 8'd0, "crc phase with payload due")

endmodule

// File: design/sfd_queue.sv
`include "assert_macros.svh"

module sfd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sfd_pkg::t_rec     i_rec,
    input  logic              i_pop,
    output sfd_pkg::t_rec     o_rec,
    output sfd_pkg::t_q_stat  o_stat
);
    import sfd_pkg::*;

    t_rec             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCntW-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_cnt == QCntW'(QDepth));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_rec        = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPtrW'(QDepth - 1)) ? '0 : r_wr_ptr + QPtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPtrW'(QDepth - 1)) ? '0 : r_rd_ptr + QPtrW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCntW'(1);
                2'b01:   r_cnt <= r_cnt - QCntW'(1);
                default: ;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    `SFD_NEVER(a_push_full, i_push && o_stat.full, "push into full queue")
    `SFD_NEVER(a_pop_empty, i_pop && o_stat.empty, "pop from empty queue")

endmodule

// File: design/sfd_back.sv
module sfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfd_pkg::t_rec     i_rec,
    input  sfd_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    sfd_out_if.source         o_res
);
    import sfd_pkg::*;

    logic        r_valid;
    logic        r_kind;
    logic [15:0] r_id;
    logic [7:0]  r_data, r_index, r_len;
    logic [15:0] r_crc;

    // load the output register when it is empty or its beat is taken
    assign o_pop = !i_q_stat.empty && (!r_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // expand the compact record into the result fields
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_rec.kind;
            r_id   <= i_rec.msg_id;
            r_len  <= i_rec.len;
            if (i_rec.kind == KIND_END) begin
                r_data  <= 8'd0;
                r_index <= 8'd0;
                r_crc   <= i_rec.val;
            end else begin
                r_data  <= i_rec.val[7:0];
                r_index <= i_rec.val[15:8];
                r_crc   <= 16'd0;
            end
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.kind       = r_kind;
    assign o_res.msg_id     = r_id;
    assign o_res.data_byte  = r_data;
    assign o_res.byte_index = r_index;
    assign o_res.frame_len  = r_len;
    assign o_res.frame_crc  = r_crc;

endmodule

// File: design/serial_frame_deframer.sv
// channel | dir | payload                                          | handshake
// i_rx    | in  | rx_byte                                          | valid/ready
// o_res   | out | kind msg_id data_byte byte_index frame_len crc   | valid/ready
// i_cfg   | in  | i_cfg_idx i_cfg_data                             | i_cfg_we
//
// one byte per cycle in while the queue has room, one result per cycle out
// while o_res is ready; a result passes front decision, queue, output register
// a two-entry queue parts the byte side from the result side, so a stalled
// output holds bytes back only once the queue is full
// synchronous active-low reset; registers return to header 165, limit 200
module serial_frame_deframer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sfd_in_if.sink                       i_rx,
    sfd_out_if.source                    o_res,
    input  logic                         i_cfg_we,
    input  logic [sfd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [7:0]                   i_cfg_data
);
    import sfd_pkg::*;

    logic    push, pop;
    t_rec    front_rec, q_rec;
    t_q_stat q_stat;

    // byte classification and frame tracking
    sfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (i_rx),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_rec      (front_rec)
    );

    // result queue
    sfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_rec   (q_rec),
        .o_stat  (q_stat)
    );

    // output formatting and register
    sfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rec    (q_rec),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RST_CYC     = 7;
    // byte to result through the two-entry queue and output register, with margin
    localparam int SETTLE_CYC  = 8;
    // longest quiet stretch of a correct run is the receiver hold-off plus a settle
    localparam int HOLD_CYC    = 80;
    localparam int WDOG_LIMIT  = 1000;
    localparam int MAX_SHOWN   = 10;
    localparam int ITEM_TARGET = 1850;
    localparam int CFG_EVERY   = 150;

    // register indexes the block does not implement
    localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_B = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [15:0] msg_id;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [7:0]  frame_len;
        logic [15:0] frame_crc;
    } deframe_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    sfd_in_if  rx_if ();
    sfd_out_if res_if ();

    serial_frame_deframer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // predictor copy of the block state and registers
    logic [7:0]  cfg_hdr;
    logic [7:0]  cfg_max;
    logic [7:0]  hdr_win [8];
    logic [3:0]  win_fill;
    logic        in_frm;
    logic [7:0]  left_cnt;
    logic [7:0]  pay_pos;
    logic [15:0] hold_id;
    logic [7:0]  hold_len;
    logic [7:0]  crc_lo;

    deframe_res_t res_due_q [$];
    int err_cnt     = 0;
    int rx_cnt      = 0;
    int res_hold_cyc = 0;
    bit rx_idle_en  = 1'b1;
    bit res_idle_en = 1'b1;

    function automatic void deframer_reset();
        cfg_hdr  = HEADER_BYTE_RST;
        cfg_max  = MAX_PAYLOAD_RST;
        foreach (hdr_win[i]) hdr_win[i] = 8'd0;
        win_fill = 4'd0;
        in_frm   = 1'b0;
        left_cnt = 8'd0;
        pay_pos  = 8'd0;
        hold_id  = 16'd0;
        hold_len = 8'd0;
        crc_lo   = 8'd0;
    endfunction

    function automatic void apply_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
        case (idx)
            CFG_HEADER_BYTE: cfg_hdr = val;
            CFG_MAX_PAYLOAD: cfg_max = val;
            default: ;
        endcase
    endfunction

    // one accepted byte: advance the deframer and queue any result it causes
    function automatic void deframe_byte(input logic [7:0] b);
        deframe_res_t r;
        logic [15:0] len16;
        bit ok;
        if (in_frm) begin
            if (left_cnt != 8'd0) begin
                r = '{KIND_PAYLOAD, hold_id, b, pay_pos, hold_len, 16'd0};
                res_due_q.push_back(r);
                pay_pos  = pay_pos + 8'd1;
                left_cnt = left_cnt - 8'd1;
            end else if (win_fill == 4'd0) begin
                crc_lo   = b;
                win_fill = 4'd1;
            end else begin
                r = '{KIND_END, hold_id, 8'd0, 8'd0, hold_len, {b, crc_lo}};
                res_due_q.push_back(r);
                in_frm   = 1'b0;
                win_fill = 4'd0;
                foreach (hdr_win[i]) hdr_win[i] = 8'd0;
            end
        end else begin
            hdr_win[win_fill[2:0]] = b;
            win_fill = win_fill + 4'd1;
            if (win_fill == 4'd8) begin
                len16 = {hdr_win[2], hdr_win[1]};
                ok = (hdr_win[0] == cfg_hdr);
                // quirk: this id with length 22 carries only 20 payload bytes
                if (hdr_win[4] == QUIRK_ID_LO && hdr_win[5] == QUIRK_ID_HI && len16 == QUIRK_LEN)
                    len16 = {8'd0, QUIRK_USELEN};
                if (len16 > {8'd0, cfg_max})
                    ok = 1'b0;
                if (!ok) begin
                    for (int i = 0; i < 7; i++) hdr_win[i] = hdr_win[i+1];
                    hdr_win[7] = 8'd0;
                    win_fill = 4'd7;
                end else begin
                    hold_id  = {hdr_win[5], hdr_win[4]};
                    hold_len = len16[7:0];
                    left_cnt = len16[7:0];
                    pay_pos  = 8'd0;
                    crc_lo   = 8'd0;
                    win_fill = 4'd0;
                    in_frm   = 1'b1;
                end
            end
        end
    endfunction

    // offer one byte after a random gap and wait for the beat
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = rx_idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        deframe_byte(b);
        rx_cnt++;
    endtask

    // header with random check and flag bytes
    task automatic send_header(input logic [7:0] hb, input logic [15:0] len, input logic [15:0] id);
        send_byte(hb);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(id[7:0]);
        send_byte(id[15:8]);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame(input logic [7:0] hb, input logic [15:0] len, input logic [15:0] id,
                              input int body_cnt);
        send_header(hb, len, id);
        repeat (body_cnt) send_byte(8'($urandom_range(0, 255)));
    endtask

    // stop offering, let every due result arrive, then let the pipe empty
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (res_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        apply_reg(idx, val);
        i_cfg_we   <= 1'b0;
    endtask

    // zero-length frame, extreme bytes and ids, a little noise
    task automatic test_directed_frames();
        send_header(HEADER_BYTE_RST, 16'd0, 16'h0000);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_header(HEADER_BYTE_RST, 16'd1, 16'hFFFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(HEADER_BYTE_RST);
        send_byte(8'hFF);
    endtask

    // writes to unused indexes must leave both registers alone
    task automatic test_spare_index();
        set_reg(CFG_IDX_SPARE_A, 8'h00);
        set_reg(CFG_IDX_SPARE_B, 8'hFF);
        send_frame(HEADER_BYTE_RST, 16'd3, 16'h1234, 5);
        send_frame(HEADER_BYTE_RST, 16'd200, 16'h4321, 0);
        send_frame(HEADER_BYTE_RST, 16'd2, 16'h00A5, 4);
    endtask

    // length 22 on the special id, either side of the limit
    task automatic test_quirk_length();
        logic [15:0] qid;
        qid = {QUIRK_ID_HI, QUIRK_ID_LO};
        send_frame(HEADER_BYTE_RST, QUIRK_LEN, qid, 22);
        send_frame(HEADER_BYTE_RST, 16'd21, qid, 23);
        send_frame(HEADER_BYTE_RST, 16'd22, 16'h2000, 24);
        set_reg(CFG_MAX_PAYLOAD, QUIRK_USELEN);
        send_frame(HEADER_BYTE_RST, QUIRK_LEN, qid, 22);
        send_frame(HEADER_BYTE_RST, 16'd22, 16'h0021, 4);
        send_frame(HEADER_BYTE_RST, 16'd4, 16'h0021, 6);
        set_reg(CFG_MAX_PAYLOAD, QUIRK_USELEN - 8'd1);
        send_frame(HEADER_BYTE_RST, QUIRK_LEN, qid, 6);
        send_frame(HEADER_BYTE_RST, 16'd19, qid, 21);
    endtask

    // limit at both extremes, high length byte, and a write in mid-frame
    task automatic test_length_limits();
        set_reg(CFG_MAX_PAYLOAD, 8'd0);
        send_frame(HEADER_BYTE_RST, 16'd0, 16'h0F0F, 2);
        send_frame(HEADER_BYTE_RST, 16'd1, 16'h0F0F, 3);
        send_frame(HEADER_BYTE_RST, 16'd0, 16'hF0F0, 2);
        set_reg(CFG_MAX_PAYLOAD, 8'd255);
        send_frame(HEADER_BYTE_RST, 16'd255, 16'h5A5A, 257);
        send_frame(HEADER_BYTE_RST, 16'h0100, 16'h5A5A, 3);
        send_frame(HEADER_BYTE_RST, 16'hFF00, 16'hA5A5, 2);
        send_frame(HEADER_BYTE_RST, 16'd1, 16'hA5A5, 3);
        set_reg(CFG_MAX_PAYLOAD, 8'd7);
        send_frame(HEADER_BYTE_RST, 16'd8, 16'h0707, 3);
        send_frame(HEADER_BYTE_RST, 16'd7, 16'h0707, 9);
        // limit change while a frame is open only matters for the next header
        send_frame(HEADER_BYTE_RST, 16'd6, 16'h0606, 3);
        set_reg(CFG_MAX_PAYLOAD, 8'd0);
        repeat (5) send_byte(8'($urandom_range(0, 255)));
        send_frame(HEADER_BYTE_RST, 16'd2, 16'h0202, 4);
        send_frame(HEADER_BYTE_RST, 16'd0, 16'h0000, 2);
        set_reg(CFG_MAX_PAYLOAD, MAX_PAYLOAD_RST);
    endtask

    // header byte at both extremes, old header no longer matches
    task automatic test_header_values();
        set_reg(CFG_HEADER_BYTE, 8'h00);
        send_frame(8'h00, 16'd2, 16'h8001, 4);
        send_frame(HEADER_BYTE_RST, 16'd2, 16'h8002, 4);
        send_frame(8'h00, 16'd0, 16'h8003, 2);
        set_reg(CFG_HEADER_BYTE, 8'hFF);
        send_frame(8'hFF, 16'd3, 16'h8004, 5);
        send_frame(8'h00, 16'd1, 16'h8005, 3);
        send_frame(8'hFF, 16'd1, 16'h8006, 3);
        set_reg(CFG_HEADER_BYTE, HEADER_BYTE_RST);
    endtask

    // long receiver hold-off against a steady sender, then a sender pause
    task automatic test_backpressure();
        rx_idle_en  = 1'b0;
        res_idle_en = 1'b0;
        res_hold_cyc = HOLD_CYC;
        send_frame(HEADER_BYTE_RST, 16'd40, 16'hBEEF, 42);
        send_header(HEADER_BYTE_RST, 16'd12, 16'hCAFE);
        repeat (5) send_byte(8'($urandom_range(0, 255)));
        settle();
        repeat (9) send_byte(8'($urandom_range(0, 255)));
        rx_idle_en  = 1'b1;
        res_idle_en = 1'b1;
    endtask

    // one well-formed, broken or noise sequence under the current registers
    task automatic send_random_unit();
        int r, used, cap;
        logic [15:0] len, id;
        logic [7:0] hb, hi;
        r  = $urandom_range(0, 99);
        id = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 19) == 0) id = {QUIRK_ID_HI, QUIRK_ID_LO};
        cap  = (cfg_max < 8'd12) ? int'(cfg_max) : 12;
        used = ($urandom_range(0, 9) < 8) ? $urandom_range(0, cap) : $urandom_range(0, cfg_max);
        len  = 16'(used);
        if (r < 70) begin
            if (id == {QUIRK_ID_HI, QUIRK_ID_LO} && cfg_max >= QUIRK_USELEN
                    && $urandom_range(0, 1) == 1) begin
                len  = QUIRK_LEN;
                used = QUIRK_USELEN;
            end
            send_frame(cfg_hdr, len, id, used + 2);
        end else if (r < 78) begin
            // length over the limit, either just over or with a high byte set
            hi = 8'($urandom_range(1, 255));
            if ($urandom_range(0, 1) == 1)
                len = 16'(cfg_max + $urandom_range(1, 20));
            else
                len = {hi, 8'($urandom_range(0, 255))};
            send_frame(cfg_hdr, len, id, $urandom_range(0, 12));
        end else if (r < 84) begin
            hb = cfg_hdr ^ 8'($urandom_range(1, 255));
            send_frame(hb, len, id, used + 2);
        end else if (r < 92) begin
            send_frame(cfg_hdr, len, id, $urandom_range(0, used + 1));
        end else begin
            repeat ($urandom_range(1, 6))
                send_byte(($urandom_range(0, 3) == 0) ? cfg_hdr : 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic randomise_regs();
        logic [7:0] hb, mp;
        case ($urandom_range(0, 3))
            0: hb = 8'h00;
            1: hb = 8'hFF;
            2: hb = HEADER_BYTE_RST;
            default: hb = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 4))
            0: mp = 8'd0;
            1: mp = 8'd255;
            2: mp = QUIRK_USELEN;
            3: mp = MAX_PAYLOAD_RST;
            default: mp = 8'($urandom_range(0, 255));
        endcase
        set_reg(CFG_HEADER_BYTE, hb);
        set_reg(CFG_MAX_PAYLOAD, mp);
        if ($urandom_range(0, 3) == 0) set_reg(CFG_IDX_SPARE_B, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_mix();
        int next_cfg;
        next_cfg = rx_cnt + CFG_EVERY;
        while (rx_cnt < ITEM_TARGET) begin
            rx_idle_en  = ($urandom_range(0, 3) != 0);
            res_idle_en = ($urandom_range(0, 3) != 0);
            send_random_unit();
            if (rx_cnt >= next_cfg) begin
                randomise_regs();
                next_cfg = rx_cnt + CFG_EVERY;
            end
        end
    endtask

    // result side: random stalls per beat, plus the requested hold-off
    initial begin : res_sink
        int n;
        res_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            n = res_hold_cyc + (res_idle_en ? $urandom_range(0, 3) : 0);
            res_hold_cyc = 0;
            if (n > 0) begin
                res_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
        end
    end

    // compare each result beat with the oldest due result
    always @(posedge i_clk) begin : res_check
        deframe_res_t got, want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got = '{res_if.kind, res_if.msg_id, res_if.data_byte, res_if.byte_index,
                    res_if.frame_len, res_if.frame_crc};
            if (res_due_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_SHOWN)
                    $display("unexpected result beat: kind %0d id %h data %h idx %0d len %0d crc %h",
                             got.kind, got.msg_id, got.data_byte, got.byte_index,
                             got.frame_len, got.frame_crc);
            end else begin
                want = res_due_q.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= MAX_SHOWN)
                        $display({"result mismatch (exp/got): kind %0d/%0d id %h/%h data %h/%h",
                                  " idx %0d/%0d len %0d/%0d crc %h/%h"},
                                 want.kind, got.kind, want.msg_id, got.msg_id,
                                 want.data_byte, got.data_byte, want.byte_index, got.byte_index,
                                 want.frame_len, got.frame_len, want.frame_crc, got.frame_crc);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin : wdog
        int quiet;
        if ((rx_if.valid === 1'b1 && rx_if.ready === 1'b1)
                || (res_if.valid === 1'b1 && res_if.ready === 1'b1))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= WDOG_LIMIT) begin
            $display("** serial_frame_deframer: FAILED **");
            $finish;
        end
    end

    initial begin : wdog_init
        wdog.quiet = 0;
    end

    initial begin : main_seq
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'd0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_HEADER_BYTE;
        i_cfg_data    <= 8'd0;
        i_rst_n       <= 1'b0;
        deframer_reset();
        repeat (RST_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_spare_index();
        test_quirk_length();
        test_length_limits();
        test_header_values();
        test_backpressure();
        test_random_mix();

        settle();
        if (err_cnt == 0) begin
            $display("** serial_frame_deframer: PASSED **");
        end else begin
            $display("** serial_frame_deframer: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/sfd_pkg.sv
design/sfd_in_if.sv
design/sfd_out_if.sv
design/sfd_front.sv
design/sfd_queue.sv
design/sfd_back.sv
design/serial_frame_deframer.sv
tb/sv/tb_top.sv
